// ===== rtl/mwq_pkg.sv =====
// Package for the mutex with waiter queue.
// Status codes, datapath command codes and the controller/datapath structs.
// No dependencies.
package mwq_pkg;

  localparam logic [2:0] ST_ACQUIRED  = 3'd0;
  localparam logic [2:0] ST_QUEUED    = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_RELEASED  = 3'd3;
  localparam logic [2:0] ST_NOT_OWNER = 3'd4;

  localparam logic OP_LOCK   = 1'b0;
  localparam logic OP_UNLOCK = 1'b1;

  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_LATCH    = 4'd1;
  localparam logic [3:0] CMD_ACQUIRE  = 4'd2;
  localparam logic [3:0] CMD_REJECT   = 4'd3;
  localparam logic [3:0] CMD_APPEND   = 4'd4;
  localparam logic [3:0] CMD_SCAN_CLR = 4'd5;
  localparam logic [3:0] CMD_SCAN_INC = 4'd6;
  localparam logic [3:0] CMD_INSERT   = 4'd7;
  localparam logic [3:0] CMD_RELEASE  = 4'd8;
  localparam logic [3:0] CMD_DENY     = 4'd9;

  typedef struct packed {
    logic [3:0] code;
  } mwq_cmd_t;

  typedef struct packed {
    logic req_unlock;
    logic held;
    logic owner_match;
    logic full;
    logic prio_mode;
    logic scan_hit;
  } mwq_stat_t;

endpackage

// ===== rtl/mwq_ctrl.sv =====
// Controller for the mutex with waiter queue.
// Sequences decode, priority scan and insert; drives datapath commands.
// Depends on mwq_pkg.
module mwq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mwq_pkg::mwq_stat_t stat,
  output mwq_pkg::mwq_cmd_t  cmd
);
  import mwq_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECIDE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.code   = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.code   = CMD_LATCH;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        if (!stat.req_unlock) begin
          if (!stat.held) begin
            cmd.code = CMD_ACQUIRE;
          end else if (stat.full) begin
            cmd.code = CMD_REJECT;
          end else if (!stat.prio_mode) begin
            cmd.code = CMD_APPEND;
          end else begin
            cmd.code   = CMD_SCAN_CLR;
            state_next = S_SCAN;
          end
        end else if (stat.owner_match) begin
          cmd.code = CMD_RELEASE;
        end else begin
          cmd.code = CMD_DENY;
        end
      end
      S_SCAN: begin
        if (stat.scan_hit) begin
          cmd.code   = CMD_INSERT;
          state_next = S_IDLE;
        end else begin
          cmd.code = CMD_SCAN_INC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mwq_dp.sv =====
// Datapath for the mutex with waiter queue.
// Owner state, shifting waiter queue, scan pointer and result registers.
// Depends on mwq_pkg.
module mwq_dp #(
  parameter int MAX_WAITERS = 16,
  parameter int ID_BITS     = 8,
  parameter int CNT_W       = 5,
  parameter int IDX_W       = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_data,
  input  logic              op,
  input  logic [7:0]        task_id,
  input  logic [7:0]        task_priority,
  input  mwq_pkg::mwq_cmd_t  cmd,
  output mwq_pkg::mwq_stat_t stat,
  output logic              done,
  output logic [2:0]        status,
  output logic              woken_valid,
  output logic [7:0]        woken_task,
  output logic              locked,
  output logic [7:0]        owner_task,
  output logic [CNT_W-1:0]  waiting_count
);
  import mwq_pkg::*;

  logic               prio_mode;
  logic               held;
  logic [ID_BITS-1:0] owner;
  logic [CNT_W-1:0]   count;
  logic [ID_BITS-1:0] ids   [MAX_WAITERS];
  logic [7:0]         prios [MAX_WAITERS];

  logic               req_op;
  logic [ID_BITS-1:0] req_id;
  logic [7:0]         req_prio;
  logic [IDX_W-1:0]   scan_idx;

  logic               emit;
  logic               wr_en;
  logic [IDX_W-1:0]   ins_pos;
  logic               nonempty;

  assign nonempty = (count != '0);
  assign emit = (cmd.code == CMD_ACQUIRE) || (cmd.code == CMD_REJECT) ||
                (cmd.code == CMD_APPEND)  || (cmd.code == CMD_INSERT) ||
                (cmd.code == CMD_RELEASE) || (cmd.code == CMD_DENY);
  assign wr_en   = (cmd.code == CMD_APPEND) || (cmd.code == CMD_INSERT);
  assign ins_pos = (cmd.code == CMD_APPEND) ? count[IDX_W-1:0] : scan_idx;

  assign stat.req_unlock  = (req_op == OP_UNLOCK);
  assign stat.held        = held;
  assign stat.owner_match = held && (owner == req_id);
  assign stat.full        = (count == CNT_W'(MAX_WAITERS));
  assign stat.prio_mode   = prio_mode;
  assign stat.scan_hit    = (CNT_W'(scan_idx) == count) || (req_prio > prios[scan_idx]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prio_mode <= 1'b0;
      held      <= 1'b0;
      owner     <= '0;
      count     <= '0;
      done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        prio_mode <= cfg_data;
      end
      done <= emit;
      unique case (cmd.code)
        CMD_ACQUIRE: begin
          held  <= 1'b1;
          owner <= req_id;
        end
        CMD_APPEND, CMD_INSERT: begin
          count <= count + CNT_W'(1);
        end
        CMD_RELEASE: begin
          held  <= 1'b0;
          owner <= '0;
          if (nonempty) begin
            count <= count - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request latch, scan pointer and result beat
  always_ff @(posedge clk) begin
    if (cmd.code == CMD_LATCH) begin
      req_op   <= op;
      req_id   <= ID_BITS'(task_id);
      req_prio <= task_priority;
    end
    if (cmd.code == CMD_SCAN_CLR) begin
      scan_idx <= '0;
    end else if (cmd.code == CMD_SCAN_INC) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (emit) begin
      woken_valid   <= 1'b0;
      woken_task    <= '0;
      locked        <= held;
      owner_task    <= held ? 8'(owner) : 8'd0;
      waiting_count <= count;
      case (cmd.code)
        CMD_ACQUIRE: begin
          status     <= ST_ACQUIRED;
          locked     <= 1'b1;
          owner_task <= 8'(req_id);
        end
        CMD_REJECT: begin
          status <= ST_FULL;
        end
        CMD_APPEND, CMD_INSERT: begin
          status        <= ST_QUEUED;
          waiting_count <= count + CNT_W'(1);
        end
        CMD_RELEASE: begin
          status      <= ST_RELEASED;
          locked      <= 1'b0;
          owner_task  <= 8'd0;
          woken_valid <= nonempty;
          if (nonempty) begin
            woken_task    <= 8'(ids[0]);
            waiting_count <= count - CNT_W'(1);
          end
        end
        default: begin
          status <= ST_NOT_OWNER;
        end
      endcase
    end
  end

  // queue cells: each takes the new request, its left or right neighbour, or keeps its own entry
  for (genvar g = 0; g < MAX_WAITERS; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (wr_en) begin
        if (IDX_W'(g) == ins_pos) begin
          ids[g]   <= req_id;
          prios[g] <= req_prio;
        end else if (g > 0) begin
          if (IDX_W'(g) > ins_pos) begin
            ids[g]   <= ids[(g > 0) ? g - 1 : 0];
            prios[g] <= prios[(g > 0) ? g - 1 : 0];
          end
        end
      end else if (cmd.code == CMD_RELEASE) begin
        if (g < MAX_WAITERS - 1) begin
          ids[g]   <= ids[(g < MAX_WAITERS - 1) ? g + 1 : g];
          prios[g] <= prios[(g < MAX_WAITERS - 1) ? g + 1 : g];
        end
      end
    end
  end

endmodule

// ===== rtl/mutex_with_wait_queue.sv =====
// Mutex with a bounded queue of waiting tasks, FIFO or priority ordered.
// busy drops as the done beat appears, so a new request is taken only
// once the last one is done; a queued lock in priority mode first scans
// the queue, one entry at a time, for its insert position. The receiver
// cannot stall done beats.
// Sync reset frees the mutex, empties the queue and selects FIFO order.
module mutex_with_wait_queue #(
  parameter int MAX_WAITERS = 16,
  parameter int ID_BITS     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic                                 cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 op,
  input  logic [7:0]                           task_id,
  input  logic [7:0]                           task_priority,
  output logic                                 done,
  output logic [2:0]                           status,
  output logic                                 woken_valid,
  output logic [7:0]                           woken_task,
  output logic                                 locked,
  output logic [7:0]                           owner_task,
  output logic [$clog2(MAX_WAITERS + 1)-1:0]   waiting_count
);
  import mwq_pkg::*;

  localparam int CNT_W = $clog2(MAX_WAITERS + 1);
  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

  mwq_cmd_t  cmd;
  mwq_stat_t stat;

  mwq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mwq_dp #(
    .MAX_WAITERS (MAX_WAITERS),
    .ID_BITS     (ID_BITS),
    .CNT_W       (CNT_W),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .op            (op),
    .task_id       (task_id),
    .task_priority (task_priority),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .woken_valid   (woken_valid),
    .woken_task    (woken_task),
    .locked        (locked),
    .owner_task    (owner_task),
    .waiting_count (waiting_count)
  );

endmodule
